// File: hw/rtl/bssf_pkg.sv
// Shared types and constants for the beacon SSID frame filter.
package bssf_pkg;

  localparam int MAX_SSID_BYTES = 32;
  localparam logic [5:0] MAC_AND_FIXED_BYTES = 6'd36;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_LEAD_BYTES  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SSID_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SSID_WORD0  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SSID_WORD1  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SSID_WORD2  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SSID_WORD3  = 3'd5;

  localparam logic [3:0]  LEAD_BYTES_RST  = 4'd6;
  localparam logic [5:0]  SSID_LENGTH_RST = 6'd17;
  // default 17-byte target name, byte 0 in the low bits
  localparam logic [63:0] SSID_WORD0_RST  = 64'h5441_4C5F_4946_4957;
  localparam logic [63:0] SSID_WORD1_RST  = 64'h5345_545F_5943_4E45;
  localparam logic [63:0] SSID_WORD2_RST  = 64'h0000_0000_0000_0054;
  localparam logic [63:0] SSID_WORD3_RST  = 64'h0000_0000_0000_0000;

  typedef struct packed {
    logic [3:0]       lead_bytes;
    logic [5:0]       ssid_length;
    logic [3:0][63:0] ssid_words;
  } bssf_cfg_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_LEN    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_NAME   = 3'd4,
    PH_DONE   = 3'd5
  } bssf_phase_t;

endpackage

// File: hw/rtl/bssf_if.sv
// Valid/ready channel interfaces for frame bytes, match results and register writes.
interface bssf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface bssf_match_if;
  logic valid;
  logic ready;
  logic is_match;
  modport source (output valid, output is_match, input ready);
  modport sink   (input valid, input is_match, output ready);
endinterface

interface bssf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/bssf_cfg_regs.sv
// Configuration register file: lead byte count, SSID length and SSID bytes.
module bssf_cfg_regs
  import bssf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bssf_cfg_if.sink   cfg_s,
  output bssf_cfg_t  cfg
);

  bssf_cfg_t cfg_r;
  bssf_cfg_t cfg_nxt;

  assign cfg_s.ready = 1'b1;
  assign cfg         = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_s.valid) begin
      unique case (cfg_s.index)
        REG_LEAD_BYTES:  cfg_nxt.lead_bytes    = cfg_s.data[3:0];
        REG_SSID_LENGTH: cfg_nxt.ssid_length   = cfg_s.data[5:0];
        REG_SSID_WORD0:  cfg_nxt.ssid_words[0] = cfg_s.data;
        REG_SSID_WORD1:  cfg_nxt.ssid_words[1] = cfg_s.data;
        REG_SSID_WORD2:  cfg_nxt.ssid_words[2] = cfg_s.data;
        REG_SSID_WORD3:  cfg_nxt.ssid_words[3] = cfg_s.data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_bytes    <= LEAD_BYTES_RST;
      cfg_r.ssid_length   <= SSID_LENGTH_RST;
      cfg_r.ssid_words[0] <= SSID_WORD0_RST;
      cfg_r.ssid_words[1] <= SSID_WORD1_RST;
      cfg_r.ssid_words[2] <= SSID_WORD2_RST;
      cfg_r.ssid_words[3] <= SSID_WORD3_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/bssf_parser.sv
// Frame parser: header skip, element walk and SSID compare, one byte per fire.
module bssf_parser
  import bssf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] frame_byte,
  input  logic       frame_end,
  input  bssf_cfg_t  cfg,
  output logic       is_match
);

  bssf_phase_t phase_r, phase_nxt;
  logic [5:0]  hdr_pos_r, hdr_pos_nxt;
  logic        id_is_ssid_r, id_is_ssid_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [5:0]  name_idx_r, name_idx_nxt;
  logic        match_r, match_nxt;
  logic        decided_r, decided_nxt;

  logic [5:0]  hdr_limit;
  logic [7:0]  target_byte;
  logic        len_bad;

  assign hdr_limit   = {2'b00, cfg.lead_bytes} + MAC_AND_FIXED_BYTES;
  assign target_byte = cfg.ssid_words[name_idx_r[4:3]][{name_idx_r[2:0], 3'b000} +: 8];
  assign len_bad     = (frame_byte != {2'b00, cfg.ssid_length}) ||
                       (cfg.ssid_length > 6'(MAX_SSID_BYTES));

  always_comb begin
    phase_nxt      = phase_r;
    hdr_pos_nxt    = hdr_pos_r;
    id_is_ssid_nxt = id_is_ssid_r;
    bytes_left_nxt = bytes_left_r;
    name_idx_nxt   = name_idx_r;
    match_nxt      = match_r;
    decided_nxt    = decided_r;
    unique case (phase_r)
      PH_HEADER: begin
        hdr_pos_nxt = hdr_pos_r + 6'd1;
        if (hdr_pos_nxt >= hdr_limit) phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_is_ssid_nxt = (frame_byte == 8'd0);
        phase_nxt      = PH_LEN;
      end
      PH_LEN: begin
        if (id_is_ssid_r) begin
          if (len_bad) begin
            match_nxt   = 1'b0;
            decided_nxt = 1'b1;
            phase_nxt   = PH_DONE;
          end else if (frame_byte == 8'd0) begin
            // empty name against an empty target
            match_nxt   = 1'b1;
            decided_nxt = 1'b1;
            phase_nxt   = PH_DONE;
          end else begin
            match_nxt      = 1'b1;
            name_idx_nxt   = 6'd0;
            bytes_left_nxt = frame_byte;
            phase_nxt      = PH_NAME;
          end
        end else if (frame_byte == 8'd0) begin
          phase_nxt = PH_ID;
        end else begin
          bytes_left_nxt = frame_byte;
          phase_nxt      = PH_SKIP;
        end
      end
      PH_SKIP: begin
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_nxt == 8'd0) phase_nxt = PH_ID;
      end
      PH_NAME: begin
        if (frame_byte != target_byte) match_nxt = 1'b0;
        name_idx_nxt   = name_idx_r + 6'd1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_nxt == 8'd0) begin
          decided_nxt = 1'b1;
          phase_nxt   = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_comb begin
    is_match = decided_nxt && match_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && frame_end)) begin
      phase_r      <= PH_HEADER;
      hdr_pos_r    <= 6'd0;
      id_is_ssid_r <= 1'b0;
      bytes_left_r <= 8'd0;
      name_idx_r   <= 6'd0;
      match_r      <= 1'b0;
      decided_r    <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      hdr_pos_r    <= hdr_pos_nxt;
      id_is_ssid_r <= id_is_ssid_nxt;
      bytes_left_r <= bytes_left_nxt;
      name_idx_r   <= name_idx_nxt;
      match_r      <= match_nxt;
      decided_r    <= decided_nxt;
    end
  end

endmodule

// File: hw/rtl/beacon_ssid_frame_filter_core.sv
// Top level of the beacon SSID frame filter: input stage, parser and result register.
//
// Frame bytes enter on in_s, one per request, with frame_end set on the last
// byte. The block skips lead_bytes bytes, the 24-byte MAC header and the 12
// fixed beacon fields, then walks the information elements. The first SSID
// element decides the frame. Each frame gives exactly one request on out_s,
// carrying is_match, produced from its last byte; other bytes give nothing.
// Registers are written on cfg_s (index 0..5), which is always ready; write
// them only while no frame is in flight.
// Throughput: one byte per cycle unless out_s stalls a frame end, set by the single
// parser state update that sits between the input register and the result register.
// Result path: the last byte is held in the input register, and when it fires
// the parser's verdict is captured in the result register that drives out_s.
// When out_s stalls, bytes that are not a frame end keep flowing; a frame end
// waits in the input register until the result register is free.
// Reset (rst_n low, synchronous) clears both stages and the parser and loads
// the register defaults: lead 6, length 17 and the 17-byte default name.
module beacon_ssid_frame_filter_core
  import bssf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  bssf_byte_if.sink    in_s,
  bssf_match_if.source out_s,
  bssf_cfg_if.sink     cfg_s
);

  bssf_cfg_t  cfg;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_match_r;
  logic       fire;
  logic       match_now;

  // advance the held byte unless it would overwrite a result still waiting
  assign fire        = in_valid_r && (!in_end_r || !out_valid_r || out_s.ready);
  assign in_s.ready  = !in_valid_r || fire;
  assign out_s.valid    = out_valid_r;
  assign out_s.is_match = out_match_r;

  bssf_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .cfg   (cfg)
  );

  bssf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .frame_byte (in_byte_r),
    .frame_end  (in_end_r),
    .cfg        (cfg),
    .is_match   (match_now)
  );

  always_comb begin
    if (in_s.valid && in_s.ready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
    if (fire && in_end_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_s.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      in_byte_r <= in_s.frame_byte;
      in_end_r  <= in_s.frame_end;
    end
    if (fire && in_end_r) begin
      out_match_r <= match_now;
    end
  end

endmodule
